// ===== rtl/core/mcsp_pkg.sv =====
package mcsp_pkg;

  // chunk header layout
  localparam int unsigned HEADER_BYTES = 6;
  localparam int unsigned NAME_MAX     = 20;

  // chunk ids
  localparam logic [15:0] ID_MAIN    = 16'h4d4d;
  localparam logic [15:0] ID_EDITOR  = 16'h3d3d;
  localparam logic [15:0] ID_OBJECT  = 16'h4000;
  localparam logic [15:0] ID_TRIMESH = 16'h4100;
  localparam logic [15:0] ID_VERTS   = 16'h4110;
  localparam logic [15:0] ID_FACES   = 16'h4120;
  localparam logic [15:0] ID_TEXCO   = 16'h4140;

  // record queue between parser and output stage
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    KIND_NAME    = 3'd0,
    KIND_VCOUNT  = 3'd1,
    KIND_VWORD   = 3'd2,
    KIND_FCOUNT  = 3'd3,
    KIND_FCORNER = 3'd4,
    KIND_TWORD   = 3'd5
  } kind_e;

  typedef struct packed {
    kind_e       record_kind;
    logic [15:0] element_index;
    logic [1:0]  component;
    logic [31:0] value;
  } rec_t;

  // parser to queue write request
  typedef struct packed {
    logic push;
    rec_t rec;
  } q_wr_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== rtl/core/mcsp_byte_if.sv =====
interface mcsp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

// ===== rtl/core/mcsp_rec_if.sv =====
interface mcsp_rec_if;
  logic        valid;
  logic        ready;
  logic [2:0]  record_kind;
  logic [15:0] element_index;
  logic [1:0]  component;
  logic [31:0] value;

  modport source (output valid, output record_kind, output element_index,
                  output component, output value, input ready);
  modport sink   (input valid, input record_kind, input element_index,
                  input component, input value, output ready);
endinterface

// ===== rtl/core/mcsp_front.sv =====
module mcsp_front
  import mcsp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  mcsp_byte_if.sink   in_i,
  input  logic        full_i,
  output q_wr_t       wr_o
);

  typedef enum logic [3:0] {
    PH_HEADER, PH_SKIP, PH_NAME, PH_VCOUNT, PH_VLIST,
    PH_FCOUNT, PH_FLIST, PH_TCOUNT, PH_TLIST
  } phase_e;

  typedef struct packed {
    logic [1:0]  comp;
    logic [15:0] elem;
    logic        last;
  } step_t;

  phase_e      phase_q, phase_d;
  logic [2:0]  hc_q, hc_d;
  logic [15:0] id_q, id_d;
  logic [31:0] len_q, len_d;
  logic [31:0] skip_q, skip_d;
  logic [15:0] lc_q, lc_d;
  logic [15:0] elem_q, elem_d;
  logic [1:0]  comp_q, comp_d;
  logic [1:0]  bp_q, bp_d;
  logic [31:0] word_q, word_d;
  logic [4:0]  nc_q, nc_d;

  logic        accept;
  logic [7:0]  b;
  logic [31:0] word_next;
  logic [31:0] len_full;
  logic [4:0]  nc_inc;
  logic [31:0] skip_dec;
  logic        emit;
  rec_t        rec;

  // advance component / element; last marks the end of the list
  function automatic step_t next_step(logic [1:0] comp, logic [15:0] elem,
                                      logic [15:0] lc, logic [2:0] ncomp);
    step_t       s;
    logic [1:0]  c1;
    logic [15:0] e1;
    c1 = comp + 2'd1;
    e1 = elem + 16'd1;
    s.last = 1'b0;
    if (({1'b0, c1} >= ncomp) || (c1 == 2'd0)) begin
      s.comp = 2'd0;
      s.elem = e1;
      s.last = (e1 == lc) || (e1 == 16'd0);
    end else begin
      s.comp = c1;
      s.elem = elem;
    end
    return s;
  endfunction

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign b          = in_i.data_byte;
  assign word_next  = ((bp_q == 2'd0) ? 32'h0 : word_q) | (32'(b) << {bp_q, 3'b000});
  assign len_full   = {b, len_q[23:0]};
  assign nc_inc     = nc_q + 5'd1;
  assign skip_dec   = skip_q - 32'd1;

  always_comb begin
    step_t st;
    phase_d = phase_q;
    hc_d    = hc_q;
    id_d    = id_q;
    len_d   = len_q;
    skip_d  = skip_q;
    lc_d    = lc_q;
    elem_d  = elem_q;
    comp_d  = comp_q;
    bp_d    = bp_q;
    word_d  = word_q;
    nc_d    = nc_q;
    emit    = 1'b0;
    rec     = '{record_kind: KIND_NAME, element_index: 16'd0, component: 2'd0,
                value: 32'd0};
    st      = next_step(comp_q, elem_q, lc_q, 3'd3);

    unique case (phase_q)
      PH_HEADER: begin
        hc_d = hc_q + 3'd1;
        unique case (hc_q)
          3'd0:    id_d = {8'h00, b};
          3'd1:    id_d = {b, id_q[7:0]};
          3'd2:    len_d = {24'h0, b};
          3'd3:    len_d = {len_q[31:16], b, len_q[7:0]};
          3'd4:    len_d = {len_q[31:24], b, len_q[15:0]};
          default: len_d = len_full;
        endcase
        if (hc_q == 3'(HEADER_BYTES - 1)) begin
          hc_d = 3'd0;
          bp_d = 2'd0;
          unique case (id_q)
            ID_MAIN, ID_EDITOR, ID_TRIMESH: phase_d = PH_HEADER;
            ID_OBJECT: begin
              nc_d    = 5'd0;
              phase_d = PH_NAME;
            end
            ID_VERTS: phase_d = PH_VCOUNT;
            ID_FACES: phase_d = PH_FCOUNT;
            ID_TEXCO: phase_d = PH_TCOUNT;
            default: begin
              if (len_full > 32'(HEADER_BYTES)) begin
                skip_d  = len_full - 32'(HEADER_BYTES);
                phase_d = PH_SKIP;
              end else begin
                skip_d  = 32'd0;
                phase_d = PH_HEADER;
              end
            end
          endcase
        end
      end

      PH_SKIP: begin
        skip_d = skip_dec;
        if (skip_dec == 32'd0) phase_d = PH_HEADER;
      end

      PH_NAME: begin
        emit = 1'b1;
        rec  = '{record_kind: KIND_NAME, element_index: {11'd0, nc_q},
                 component: 2'd0, value: {24'h0, b}};
        nc_d = nc_inc;
        if ((b == 8'h00) || (nc_inc >= 5'(NAME_MAX)) || (nc_inc == 5'd0))
          phase_d = PH_HEADER;
      end

      PH_VCOUNT, PH_FCOUNT, PH_TCOUNT: begin
        word_d = word_next;
        bp_d   = bp_q + 2'd1;
        if (bp_q == 2'd1) begin
          lc_d   = word_next[15:0];
          elem_d = 16'd0;
          comp_d = 2'd0;
          bp_d   = 2'd0;
          if (phase_q == PH_VCOUNT) begin
            emit = 1'b1;
            rec  = '{record_kind: KIND_VCOUNT, element_index: 16'd0,
                     component: 2'd0, value: {16'h0, word_next[15:0]}};
          end else if (phase_q == PH_FCOUNT) begin
            emit = 1'b1;
            rec  = '{record_kind: KIND_FCOUNT, element_index: 16'd0,
                     component: 2'd0, value: {16'h0, word_next[15:0]}};
          end
          if (word_next[15:0] == 16'd0) phase_d = PH_HEADER;
          else if (phase_q == PH_VCOUNT) phase_d = PH_VLIST;
          else if (phase_q == PH_FCOUNT) phase_d = PH_FLIST;
          else phase_d = PH_TLIST;
        end
      end

      PH_VLIST, PH_TLIST: begin
        word_d = word_next;
        bp_d   = bp_q + 2'd1;
        if (bp_q == 2'd3) begin
          bp_d = 2'd0;
          emit = 1'b1;
          rec  = '{record_kind: (phase_q == PH_VLIST) ? KIND_VWORD : KIND_TWORD,
                   element_index: elem_q, component: comp_q, value: word_next};
          st   = next_step(comp_q, elem_q, lc_q, (phase_q == PH_VLIST) ? 3'd3 : 3'd2);
          comp_d = st.comp;
          elem_d = st.elem;
          if (st.last) phase_d = PH_HEADER;
        end
      end

      PH_FLIST: begin
        word_d = word_next;
        bp_d   = bp_q + 2'd1;
        if (bp_q == 2'd1) begin
          bp_d = 2'd0;
          // fourth word of each face is the flag word, dropped
          if (comp_q != 2'd3) begin
            emit = 1'b1;
            rec  = '{record_kind: KIND_FCORNER, element_index: elem_q,
                     component: comp_q, value: {16'h0, word_next[15:0]}};
          end
          st     = next_step(comp_q, elem_q, lc_q, 3'd4);
          comp_d = st.comp;
          elem_d = st.elem;
          if (st.last) phase_d = PH_HEADER;
        end
      end

      default: begin
        phase_d = PH_HEADER;
        hc_d    = 3'd0;
      end
    endcase
  end

  assign wr_o.push = accept && emit;
  assign wr_o.rec  = rec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      hc_q    <= 3'd0;
      id_q    <= 16'd0;
      len_q   <= 32'd0;
      skip_q  <= 32'd0;
      lc_q    <= 16'd0;
      elem_q  <= 16'd0;
      comp_q  <= 2'd0;
      bp_q    <= 2'd0;
      word_q  <= 32'd0;
      nc_q    <= 5'd0;
    end else if (accept) begin
      phase_q <= phase_d;
      hc_q    <= hc_d;
      id_q    <= id_d;
      len_q   <= len_d;
      skip_q  <= skip_d;
      lc_q    <= lc_d;
      elem_q  <= elem_d;
      comp_q  <= comp_d;
      bp_q    <= bp_d;
      word_q  <= word_d;
      nc_q    <= nc_d;
    end
  end

`ifndef SYNTHESIS
  a_skip_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_SKIP) |-> (skip_q != 32'd0))
    else $error("skip phase with nothing left to skip");

  a_hdr_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_HEADER) |-> (hc_q < 3'(HEADER_BYTES)))
    else $error("header byte count out of range");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_o.push |-> !full_i)
    else $error("record pushed into full queue");
`endif

endmodule

// ===== rtl/core/mcsp_queue.sv =====
module mcsp_queue
  import mcsp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  q_wr_t   wr_i,
  input  logic    pop_i,
  output rec_t    head_o,
  output q_stat_t stat_o
);

  rec_t                mem_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wptr_q, rptr_q;
  logic [QUEUE_AW:0]   cnt_q;

  assign head_o       = mem_q[rptr_q];
  assign stat_o.full  = (cnt_q == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign stat_o.empty = (cnt_q == '0);

  always_ff @(posedge clk_i) begin
    if (wr_i.push) mem_q[wptr_q] <= wr_i.rec;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (wr_i.push) wptr_q <= wptr_q + 1'b1;
      if (pop_i)     rptr_q <= rptr_q + 1'b1;
      if (wr_i.push && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (!wr_i.push && pop_i) cnt_q <= cnt_q - 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (QUEUE_AW + 1)'(QUEUE_DEPTH))
    else $error("queue overflow");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !stat_o.empty)
    else $error("pop from empty queue");
`endif

endmodule

// ===== rtl/core/mcsp_back.sv =====
module mcsp_back
  import mcsp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  q_stat_t   stat_i,
  input  rec_t      head_i,
  output logic      pop_o,
  mcsp_rec_if.source out_o
);

  logic valid_q;
  rec_t rec_q;

  // refill the output register whenever it is empty or being drained
  assign pop_o = !stat_i.empty && (!valid_q || out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) rec_q <= head_i;
  end

  assign out_o.valid         = valid_q;
  assign out_o.record_kind   = rec_q.record_kind;
  assign out_o.element_index = rec_q.element_index;
  assign out_o.component     = rec_q.component;
  assign out_o.value         = rec_q.value;

endmodule

// ===== rtl/core/mesh_chunk_stream_parser.sv =====
// 3ds chunk stream parser, one file byte per request on in_i
// path: each record passes through the record queue and then the output register to out_o
// throughput: one byte per cycle while the record queue is not full; the four-entry queue absorbs output stalls
// the parser stalls input only while the record queue is full
// reset: rst_ni asynchronous active low; parser returns to header phase, queue and output empty
module mesh_chunk_stream_parser
  import mcsp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  mcsp_byte_if.sink  in_i,
  mcsp_rec_if.source out_o
);

  // parser front end to record queue
  q_wr_t   wr;
  // queue status, shared by front and back
  q_stat_t stat;
  // queue head and pop from output stage
  rec_t    head;
  logic    pop;

  // front: walks chunk headers and lists, builds one record per emitting byte
  mcsp_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (stat.full),
    .wr_o   (wr)
  );

  // short queue decouples the byte side from the record side
  mcsp_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (wr),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (stat)
  );

  // back: registered output stage driving the record channel
  mcsp_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .head_i (head),
    .pop_o  (pop),
    .out_o  (out_o)
  );

endmodule

// ===== tb/sv/tb_mesh_chunk_stream_parser.sv =====
`timescale 1ns / 100ps

module tb_mesh_chunk_stream_parser;
  import mcsp_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 250000;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned PHASE_BYTES  = 280;
  localparam int unsigned PRINT_CAP    = 60;

  // idling per random phase: none, sender idle, receiver stalling, both
  localparam int unsigned SRC_IDLE[4]  = '{0, 71, 0, 12};
  localparam int unsigned SNK_STALL[4] = '{0, 0, 71, 12};

  // parser phases as the predictor tracks them
  typedef enum logic [3:0] {
    P_HEADER = 4'd0,
    P_SKIP   = 4'd1,
    P_NAME   = 4'd2,
    P_VCOUNT = 4'd3,
    P_VLIST  = 4'd4,
    P_FCOUNT = 4'd5,
    P_FLIST  = 4'd6,
    P_TCOUNT = 4'd7,
    P_TLIST  = 4'd8
  } parse_phase_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  mcsp_byte_if in_if ();
  mcsp_rec_if  out_if ();

  mesh_chunk_stream_parser dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #6 clk_i = ~clk_i;

  // predictor state, at its reset values
  parse_phase_e ph        = P_HEADER;
  int unsigned  hdr_cnt   = 0;
  logic [15:0]  cur_id    = '0;
  logic [31:0]  cur_len   = '0;
  logic [31:0]  skip_left = '0;
  logic [15:0]  list_len  = '0;
  logic [15:0]  elem_idx  = '0;
  logic [1:0]   comp_idx  = '0;
  logic [1:0]   byte_pos  = '0;
  logic [31:0]  word_acc  = '0;
  logic [4:0]   name_idx  = '0;

  logic [7:0]   stream_bytes[$];     // file bytes waiting to be sent
  rec_t         pending_records[$];  // records predicted but not yet seen
  rec_t         next_record;

  int unsigned src_idle_pct  = 0;
  int unsigned snk_stall_pct = 0;
  int unsigned bytes_built   = 0;
  int unsigned err_cnt       = 0;
  int unsigned cycle_cnt     = 0;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic void add_record(kind_e kind, logic [15:0] idx, logic [1:0] comp,
                                     logic [31:0] val);
    rec_t r;
    r.record_kind   = kind;
    r.element_index = idx;
    r.component     = comp;
    r.value         = val;
    pending_records.push_back(r);
  endfunction

  // little-endian word assembly, true once nbytes bytes are in
  function automatic bit gather_byte(logic [7:0] b, int unsigned nbytes);
    if (byte_pos == 2'd0) word_acc = '0;
    word_acc = word_acc | (32'(b) << (8 * byte_pos));
    byte_pos = byte_pos + 2'd1;
    if (byte_pos >= nbytes || byte_pos == 2'd0) begin
      byte_pos = 2'd0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // a zero count ends the chunk right away
  function automatic void open_list(parse_phase_e list_phase);
    list_len = word_acc[15:0];
    elem_idx = '0;
    comp_idx = '0;
    byte_pos = '0;
    ph = (list_len == 16'd0) ? P_HEADER : list_phase;
  endfunction

  function automatic void advance_component(int unsigned ncomp);
    comp_idx = comp_idx + 2'd1;
    if (comp_idx >= ncomp || comp_idx == 2'd0) begin
      comp_idx = '0;
      elem_idx = elem_idx + 16'd1;
      if (elem_idx == list_len || elem_idx == 16'd0) ph = P_HEADER;
    end
  endfunction

  // one accepted file byte in, expected records appended
  function automatic void parse_byte(logic [7:0] b);
    case (ph)
      P_HEADER: begin
        if (hdr_cnt == 0) begin
          cur_id  = '0;
          cur_len = '0;
        end
        if (hdr_cnt < 2) cur_id = cur_id | (16'(b) << (8 * hdr_cnt));
        else cur_len = cur_len | (32'(b) << (8 * (hdr_cnt - 2)));
        hdr_cnt++;
        if (hdr_cnt >= HEADER_BYTES) begin
          hdr_cnt  = 0;
          byte_pos = '0;
          case (cur_id)
            ID_MAIN, ID_EDITOR, ID_TRIMESH: ph = P_HEADER;  // containers
            ID_OBJECT: begin
              name_idx = '0;
              ph = P_NAME;
            end
            ID_VERTS: ph = P_VCOUNT;
            ID_FACES: ph = P_FCOUNT;
            ID_TEXCO: ph = P_TCOUNT;
            default: begin
              // short length skips nothing
              if (cur_len > HEADER_BYTES) begin
                skip_left = cur_len - HEADER_BYTES;
                ph = P_SKIP;
              end else begin
                skip_left = '0;
                ph = P_HEADER;
              end
            end
          endcase
        end
      end
      P_SKIP: begin
        skip_left = skip_left - 32'd1;
        if (skip_left == 32'd0) ph = P_HEADER;
      end
      P_NAME: begin
        add_record(KIND_NAME, {11'b0, name_idx}, 2'd0, {24'b0, b});
        name_idx = name_idx + 5'd1;
        if (b == 8'd0 || name_idx >= NAME_MAX || name_idx == 5'd0) ph = P_HEADER;
      end
      P_VCOUNT: begin
        if (gather_byte(b, 2)) begin
          open_list(P_VLIST);
          add_record(KIND_VCOUNT, 16'd0, 2'd0, {16'b0, list_len});
        end
      end
      P_FCOUNT: begin
        if (gather_byte(b, 2)) begin
          open_list(P_FLIST);
          add_record(KIND_FCOUNT, 16'd0, 2'd0, {16'b0, list_len});
        end
      end
      P_TCOUNT: begin
        // texcoord count gives no record
        if (gather_byte(b, 2)) open_list(P_TLIST);
      end
      P_VLIST: begin
        if (gather_byte(b, 4)) begin
          add_record(KIND_VWORD, elem_idx, comp_idx, word_acc);
          advance_component(3);
        end
      end
      P_TLIST: begin
        if (gather_byte(b, 4)) begin
          add_record(KIND_TWORD, elem_idx, comp_idx, word_acc);
          advance_component(2);
        end
      end
      P_FLIST: begin
        // fourth word of a face is the flag word, dropped
        if (gather_byte(b, 2)) begin
          if (comp_idx < 2'd3)
            add_record(KIND_FCORNER, elem_idx, comp_idx, {16'b0, word_acc[15:0]});
          advance_component(4);
        end
      end
      default: begin
        ph = P_HEADER;
        hdr_cnt = 0;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // file stream builders
  // ---------------------------------------------------------------------------

  function automatic void put_byte(logic [7:0] b);
    stream_bytes.push_back(b);
    bytes_built++;
  endfunction

  function automatic void put_u16(logic [15:0] v);
    put_byte(v[7:0]);
    put_byte(v[15:8]);
  endfunction

  function automatic void put_u32(logic [31:0] v);
    put_u16(v[15:0]);
    put_u16(v[31:16]);
  endfunction

  function automatic void put_header(logic [15:0] id, logic [31:0] len);
    put_u16(id);
    put_u32(len);
  endfunction

  // n nonzero name bytes, zero terminated when shorter than the name limit
  function automatic void put_name_chunk(int unsigned n);
    put_header(ID_OBJECT, $urandom());
    for (int unsigned i = 0; i < n && i < NAME_MAX; i++)
      put_byte(8'($urandom_range(255, 1)));
    if (n < NAME_MAX) put_byte(8'd0);
  endfunction

  function automatic void put_vert_chunk(int unsigned count);
    put_header(ID_VERTS, HEADER_BYTES + 2 + 12 * count);
    put_u16(16'(count));
    repeat (3 * count) put_u32($urandom());
  endfunction

  function automatic void put_face_chunk(int unsigned count);
    put_header(ID_FACES, HEADER_BYTES + 2 + 8 * count);
    put_u16(16'(count));
    repeat (4 * count) put_u16(16'($urandom()));
  endfunction

  function automatic void put_tex_chunk(int unsigned count);
    put_header(ID_TEXCO, HEADER_BYTES + 2 + 8 * count);
    put_u16(16'(count));
    repeat (2 * count) put_u32($urandom());
  endfunction

  // chunk id that the parser does not know, body of random bytes
  function automatic void put_unknown_chunk(logic [31:0] len);
    logic [15:0] id;
    id = 16'($urandom());
    case (id)
      ID_MAIN, ID_EDITOR, ID_OBJECT, ID_TRIMESH, ID_VERTS, ID_FACES, ID_TEXCO:
        id[0] = ~id[0];
      default: ;
    endcase
    put_header(id, len);
    if (len > HEADER_BYTES) repeat (len - HEADER_BYTES) put_byte(8'($urandom()));
  endfunction

  function automatic int unsigned pick_count();
    return ($urandom_range(9) < 8) ? $urandom_range(4, 0) : $urandom_range(12, 5);
  endfunction

  // well-formed model with random content; container lengths are random noise
  function automatic void put_random_model();
    put_header(ID_MAIN, $urandom());
    put_header(ID_EDITOR, $urandom());
    repeat ($urandom_range(4, 1)) begin
      case ($urandom_range(9))
        0, 1:    put_name_chunk($urandom_range(NAME_MAX, 0));
        2:       put_header(ID_TRIMESH, $urandom());
        3, 4:    put_vert_chunk(pick_count());
        5, 6:    put_face_chunk(pick_count());
        7:       put_tex_chunk(pick_count());
        default: begin
          case ($urandom_range(3))
            0:       put_unknown_chunk($urandom_range(HEADER_BYTES - 1, 0));
            1:       put_unknown_chunk(HEADER_BYTES);
            2:       put_unknown_chunk($urandom_range(20, HEADER_BYTES + 1));
            default: put_unknown_chunk($urandom_range(300, 21));
          endcase
        end
      endcase
    end
  endfunction

  // ---------------------------------------------------------------------------
  // mismatch reporting
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string msg);
    if (err_cnt < PRINT_CAP) $display("%0t mismatch: %s", $realtime, msg);
    err_cnt++;
  endtask

  // ---------------------------------------------------------------------------
  // byte driver: one request per accepted file byte, random sender gaps
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else begin
      // predict from the byte that this edge accepts
      if (in_if.valid && in_if.ready) parse_byte(in_if.data_byte);
      // load the next byte once the slot is free
      if (!in_if.valid || in_if.ready) begin
        if (stream_bytes.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          in_if.valid     <= 1'b1;
          in_if.data_byte <= stream_bytes.pop_front();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // record monitor: field-by-field check against the oldest prediction
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (pending_records.size() == 0) begin
          report_mismatch($sformatf("unexpected record kind %0d idx %0d comp %0d value %h",
                                    out_if.record_kind, out_if.element_index,
                                    out_if.component, out_if.value));
        end else begin
          next_record = pending_records.pop_front();
          if (out_if.record_kind !== next_record.record_kind)
            report_mismatch($sformatf("record_kind %0d, want %0d",
                                      out_if.record_kind, next_record.record_kind));
          if (out_if.element_index !== next_record.element_index)
            report_mismatch($sformatf("element_index %0d, want %0d",
                                      out_if.element_index, next_record.element_index));
          if (out_if.component !== next_record.component)
            report_mismatch($sformatf("component %0d, want %0d",
                                      out_if.component, next_record.component));
          if (out_if.value !== next_record.value)
            report_mismatch($sformatf("value %h, want %h",
                                      out_if.value, next_record.value));
        end
      end
      out_if.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // run time limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb_mesh_chunk_stream_parser: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------

  initial begin
    in_if.valid     = 1'b0;
    in_if.data_byte = '0;
    out_if.ready    = 1'b0;

    // directed: containers, name endings, empty and single-element lists,
    // field extremes, short and exact unknown lengths
    put_header(ID_MAIN, 32'hffff_ffff);
    put_header(ID_EDITOR, 32'd0);
    put_name_chunk(2);
    put_name_chunk(0);
    put_name_chunk(NAME_MAX);
    put_header(ID_TRIMESH, 32'h8000_0000);
    put_vert_chunk(0);
    put_header(ID_VERTS, 32'd20);
    put_u16(16'd1);
    put_u32(32'h0000_0000);
    put_u32(32'hffff_ffff);
    put_u32(32'h8000_0000);
    put_face_chunk(0);
    put_header(ID_FACES, 32'd16);
    put_u16(16'd1);
    put_u16(16'h0000);
    put_u16(16'hffff);
    put_u16(16'h1234);
    put_u16(16'habcd);
    put_tex_chunk(0);
    put_header(ID_TEXCO, 32'd16);
    put_u16(16'd1);
    put_u32(32'hffff_ffff);
    put_u32(32'h0000_0000);
    put_unknown_chunk(32'd0);
    put_unknown_chunk(HEADER_BYTES - 1);
    put_unknown_chunk(HEADER_BYTES);
    put_unknown_chunk(HEADER_BYTES + 3);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (stream_bytes.size() != 0) @(negedge clk_i);

    // random models, one idling pattern per phase
    for (int p = 0; p < 4; p++) begin
      src_idle_pct  = SRC_IDLE[p];
      snk_stall_pct = SNK_STALL[p];
      bytes_built   = 0;
      while (bytes_built < PHASE_BYTES) put_random_model();
      while (stream_bytes.size() != 0) @(negedge clk_i);
    end

    // last request accepted, then all records out, then a quiet drain period
    while (stream_bytes.size() != 0 || in_if.valid) @(negedge clk_i);
    while (pending_records.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (err_cnt == 0) begin
      $display("tb_mesh_chunk_stream_parser: clean");
    end else begin
      $display("tb_mesh_chunk_stream_parser: errors");
    end
    $finish;
  end

endmodule
